// ===== sv/bbtc_pkg.sv =====
// shared types, constants and margin check for the bounding box tile cache
`default_nettype none

package bbtc_pkg;

    // default table depth and sensitivity after reset
    localparam int unsigned ENTRIES_DEFAULT = 16;
    localparam logic [30:0] SENS_RESET      = 31'd100;

    // result status codes
    typedef enum logic [1:0] {
        ST_STORED = 2'd0,
        ST_HIT    = 2'd1,
        ST_MISS   = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // controller states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } t_state;

    // one box, edges as signed map units
    typedef struct packed {
        logic [31:0] top;
        logic [31:0] bottom;
        logic [31:0] left;
        logic [31:0] right;
    } t_box;

    // query token handed from cell to cell
    typedef struct packed {
        logic        active;
        logic        hit;
        t_box        box;
        logic [31:0] handle;
        logic [7:0]  index;
    } t_probe;

    // outer edge strictly beyond inner edge by less than the sensitivity
    function automatic logic margin_ok(input logic [31:0] outer,
                                       input logic [31:0] inner,
                                       input logic [30:0] sens);
        logic [32:0] d;
        d = {outer[31], outer} - {inner[31], inner};
        return !d[32] && (d != 33'd0) && (d[31:0] < {1'b0, sens});
    endfunction

endpackage

`default_nettype wire

// ===== sv/bbtc_cell.sv =====
// one table slot: holds a box and handle, checks the passing query token
`default_nettype none

module bbtc_cell
    import bbtc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_wr_en,
    input  wire t_box        i_wr_box,
    input  wire logic [31:0] i_wr_handle,
    input  wire logic        i_enable,
    input  wire logic [7:0]  i_index,
    input  wire logic [30:0] i_sens,
    input  wire t_probe      i_probe,
    output t_probe           o_probe
);

    t_box        r_box;
    logic [31:0] r_handle;
    t_probe      r_probe;
    t_probe      n_probe;
    logic        w_match;

    // slot storage, written once by a store transaction
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_box    <= i_wr_box;
            r_handle <= i_wr_handle;
        end
    end

    // strict enclosure with every margin below the sensitivity
    always_comb begin
        w_match = margin_ok(r_box.top, i_probe.box.top, i_sens)
               && margin_ok(i_probe.box.bottom, r_box.bottom, i_sens)
               && margin_ok(i_probe.box.left, r_box.left, i_sens)
               && margin_ok(r_box.right, i_probe.box.right, i_sens);
    end

    // first matching slot claims the token
    always_comb begin
        n_probe = i_probe;
        if (i_probe.active && !i_probe.hit && i_enable && w_match) begin
            n_probe.hit    = 1'b1;
            n_probe.handle = r_handle;
            n_probe.index  = i_index;
        end
    end

    // token register toward the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.active <= 1'b0;
        end else begin
            r_probe.active <= n_probe.active;
        end
        r_probe.hit    <= n_probe.hit;
        r_probe.box    <= n_probe.box;
        r_probe.handle <= n_probe.handle;
        r_probe.index  <= n_probe.index;
    end

    assign o_probe = r_probe;

endmodule

`default_nettype wire

// ===== sv/bounding_box_tile_cache.sv =====
// top level: store/lookup control, output register and the chain of slot cells
// store transaction: the result goes straight into the output register at acceptance
// lookup transaction: the query token walks the chain one cell per cycle, through every cell
// register and then into the output register; no new transaction is taken meanwhile
// throughput: one store per cycle while the receiver keeps taking results; lookups never overlap
// reset (synchronous, active low) empties the table and sets sensitivity to 100
`default_nettype none

module bounding_box_tile_cache
    import bbtc_pkg::*;
#(
    parameter int unsigned ENTRIES = ENTRIES_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [30:0] i_cfg_wdata,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_action,
    input  wire logic [31:0] i_top,
    input  wire logic [31:0] i_bottom,
    input  wire logic [31:0] i_left,
    input  wire logic [31:0] i_right,
    input  wire logic [31:0] i_image_handle,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [31:0]      o_found_handle,
    output logic [7:0]       o_found_index
);

    localparam int unsigned CW = $clog2(ENTRIES + 1);
    localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    t_state      r_state;
    t_state      n_state;
    logic [CW-1:0] r_count;
    logic [30:0] r_sens;
    logic        r_out_valid;
    t_status     r_status;
    logic [31:0] r_handle;
    logic [7:0]  r_index;
    logic        w_accept;
    logic        w_store;
    logic        w_full;
    logic        w_store_ok;
    logic        w_done;
    t_box        w_box;
    t_probe      w_chain [ENTRIES+1];

    assign w_accept   = i_valid && o_ready;
    assign w_store    = w_accept && !i_action;
    assign w_full     = (r_count == CW'(ENTRIES));
    assign w_store_ok = w_store && !w_full;
    assign w_done     = w_chain[ENTRIES].active;
    assign w_box      = '{top: i_top, bottom: i_bottom, left: i_left, right: i_right};

    // query token entering the first cell
    always_comb begin
        w_chain[0].active = w_accept && i_action;
        w_chain[0].hit    = 1'b0;
        w_chain[0].box    = w_box;
        w_chain[0].handle = 32'd0;
        w_chain[0].index  = 8'd0;
    end

    // row of slot cells
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        bbtc_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_wr_en     (w_store_ok && (r_count[IW-1:0] == IW'(g))),
            .i_wr_box    (w_box),
            .i_wr_handle (i_image_handle),
            .i_enable    (CW'(g) < r_count),
            .i_index     (8'(g)),
            .i_sens      (r_sens),
            .i_probe     (w_chain[g]),
            .o_probe     (w_chain[g+1])
        );
    end

    // sensitivity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens <= SENS_RESET;
        end else if (i_cfg_we) begin
            r_sens <= i_cfg_wdata;
        end
    end

    // fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_store_ok) begin
            r_count <= r_count + CW'(1);
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_action) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE:  o_ready = !r_out_valid || i_ready;
            S_SCAN:  o_ready = 1'b0;
            default: o_ready = 1'b0;
        endcase
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_store || w_done) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_status <= w_full ? ST_FULL : ST_STORED;
            r_handle <= 32'd0;
            r_index  <= w_full ? 8'd0 : 8'(r_count);
        end else if (w_done) begin
            r_status <= w_chain[ENTRIES].hit ? ST_HIT : ST_MISS;
            r_handle <= w_chain[ENTRIES].handle;
            r_index  <= w_chain[ENTRIES].index;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_found_handle = r_handle;
    assign o_found_index  = r_index;

    // fill count never passes the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ENTRIES))
        else $error("fill count beyond table depth");

    // a store into a table with room grows the count by one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_store_ok |=> r_count == $past(r_count) + CW'(1))
        else $error("fill count did not advance on store");

    // a token leaving the chain finds the controller scanning and the output free
    a_done_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == S_SCAN) && !r_out_valid)
        else $error("lookup finished with output register busy");

    // a hit always names a filled slot
    a_hit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == ST_HIT)) |-> (9'(r_index) < 9'(r_count)))
        else $error("hit on unfilled slot");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// testbench for the bounding box tile cache: directed and random stores and lookups checked against a predictor
`timescale 1ns / 1ps

module tb_top
    import bbtc_pkg::*;
();

    localparam int unsigned TABLE_SLOTS = ENTRIES_DEFAULT;
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned PHASE_ITEMS = 250;

    // item actions
    localparam logic ACT_STORE  = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    // one expected reply
    typedef struct {
        t_status     status;
        logic [31:0] handle;
        logic [7:0]  index;
    } t_reply;

    // predicted tile table and the replies still owed by the block
    class tile_cache_checker;
        t_box        boxes[TABLE_SLOTS];
        logic [31:0] handles[TABLE_SLOTS];
        int unsigned fill;
        logic [30:0] sens;
        t_reply      pending_replies[$];
        int unsigned errors;
        int unsigned n_stored, n_full, n_hit, n_miss;

        function new();
            fill     = 0;
            sens     = SENS_RESET;
            errors   = 0;
            n_stored = 0;
            n_full   = 0;
            n_hit    = 0;
            n_miss   = 0;
        endfunction

        // outer edge lies beyond inner edge by a margin in (0, sens)
        function bit edge_clear(logic [31:0] outer, logic [31:0] inner);
            longint margin;
            margin = longint'($signed(outer)) - longint'($signed(inner));
            return (margin > 0) && (margin < longint'(sens));
        endfunction

        // accepted transaction: update the table and queue its reply
        function void note_request(logic action, t_box q, logic [31:0] handle);
            t_reply      r;
            bit          found;
            int unsigned i;
            r.status = ST_MISS;
            r.handle = '0;
            r.index  = '0;
            found    = 1'b0;
            if (action == ACT_STORE) begin
                if (fill >= TABLE_SLOTS) begin
                    r.status = ST_FULL;
                end else begin
                    boxes[fill]   = q;
                    handles[fill] = handle;
                    r.status      = ST_STORED;
                    r.index       = 8'(fill);
                    fill++;
                end
            end else begin
                for (i = 0; i < fill && !found; i++) begin
                    if (edge_clear(boxes[i].top, q.top) &&
                        edge_clear(q.bottom, boxes[i].bottom) &&
                        edge_clear(q.left, boxes[i].left) &&
                        edge_clear(boxes[i].right, q.right)) begin
                        found    = 1'b1;
                        r.status = ST_HIT;
                        r.handle = handles[i];
                        r.index  = 8'(i);
                    end
                end
            end
            pending_replies = {pending_replies, r};
        endfunction

        // accepted reply: compare with the oldest expectation
        function void check_reply(logic [1:0] status, logic [31:0] handle,
                                  logic [7:0] index);
            t_reply e;
            if (pending_replies.size() == 0) begin
                $display("%0t: reply with nothing expected: status %0d handle %h index %0d",
                         $time, status, handle, index);
                errors++;
                return;
            end
            e = pending_replies.pop_front();
            case (e.status)
                ST_STORED: n_stored++;
                ST_FULL:   n_full++;
                ST_HIT:    n_hit++;
                default:   n_miss++;
            endcase
            if (status !== e.status) begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, e.status, status);
                errors++;
            end
            if (handle !== e.handle) begin
                $display("%0t: found_handle mismatch: expected %h, actual %h",
                         $time, e.handle, handle);
                errors++;
            end
            if (index !== e.index) begin
                $display("%0t: found_index mismatch: expected %0d, actual %0d",
                         $time, e.index, index);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_we       = 1'b0;
    logic [30:0] i_cfg_wdata    = '0;
    logic        i_valid        = 1'b0;
    logic        o_ready;
    logic        i_action       = ACT_STORE;
    logic [31:0] i_top          = '0;
    logic [31:0] i_bottom       = '0;
    logic [31:0] i_left         = '0;
    logic [31:0] i_right        = '0;
    logic [31:0] i_image_handle = '0;
    logic        o_valid;
    logic        i_ready        = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_found_handle;
    logic [7:0]  o_found_index;

    tile_cache_checker sb;
    bit          idle_on      = 1'b1;
    int unsigned long_hold    = 0;
    int unsigned stall_left   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned n_settings   = 0;

    bounding_box_tile_cache #(
        .ENTRIES(TABLE_SLOTS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_top         (i_top),
        .i_bottom      (i_bottom),
        .i_left        (i_left),
        .i_right       (i_right),
        .i_image_handle(i_image_handle),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_found_handle(o_found_handle),
        .o_found_index (o_found_index)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // input transaction monitor
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            sb.note_request(i_action,
                            '{top: i_top, bottom: i_bottom, left: i_left, right: i_right},
                            i_image_handle);
        end
    end

    // output transaction monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_reply(o_status, o_found_handle, o_found_index);
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // gap length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver: random stalls, plus a long hold-off when requested
    initial begin
        forever begin
            @(negedge i_clk);
            if (long_hold > 0) begin
                i_ready <= 1'b0;
                long_hold--;
            end else if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 99) < 30) stall_left = pick_gap();
            end
        end
    end

    // offer one transaction and hold it until accepted
    task automatic send_item(input logic action, input t_box q, input logic [31:0] handle);
        int unsigned gap;
        gap = idle_on ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_action       <= action;
        i_top          <= q.top;
        i_bottom       <= q.bottom;
        i_left         <= q.left;
        i_right        <= q.right;
        i_image_handle <= handle;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // stop offering and wait for every outstanding reply
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending_replies.size() != 0) @(posedge i_clk);
        repeat (TABLE_SLOTS + 4) @(posedge i_clk);
    endtask

    // sensitivity write while the block is idle
    task automatic set_sensitivity(input logic [30:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.sens = value;
        n_settings++;
    endtask

    // half size of a random box, mostly small
    function automatic longint pick_extent();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return longint'($urandom_range(1, 200));
        if (r < 85) return longint'($urandom_range(1, 1 << 20));
        return longint'($urandom_range(1, 32'h7fff_ffff));
    endfunction

    // box around a random center, wrapping at the 32-bit range
    function automatic t_box random_box();
        t_box   b;
        longint cv, ch, hv, hh;
        cv = longint'($signed($urandom()));
        ch = longint'($signed($urandom()));
        hv = pick_extent();
        hh = pick_extent();
        b.top    = 32'(cv + hv);
        b.bottom = 32'(cv - hv);
        b.left   = 32'(ch - hh);
        b.right  = 32'(ch + hh);
        return b;
    endfunction

    function automatic t_box noise_box();
        t_box b;
        b.top    = $urandom();
        b.bottom = $urandom();
        b.left   = $urandom();
        b.right  = $urandom();
        return b;
    endfunction

    // margin for one edge: inside the window, or on and past its limits
    function automatic longint pick_margin(input bit all_in);
        longint      s;
        int unsigned r;
        s = longint'(sb.sens);
        if (all_in || $urandom_range(0, 99) < 60) begin
            return (s >= 2) ? longint'($urandom_range(1, 32'(s - 1))) : 1;
        end
        r = $urandom_range(0, 99);
        if (r < 25) return (s >= 1) ? s - 1 : 0;
        if (r < 50) return s;
        if (r < 65) return 0;
        if (r < 80) return 1;
        if (r < 90) return -longint'($urandom_range(1, 100));
        return longint'($urandom_range(0, 32'h7fff_ffff));
    endfunction

    // query built inside (or around) one stored box
    function automatic t_box enclosed_query(input int unsigned slot);
        t_box s, q;
        bit   all_in;
        s      = sb.boxes[slot];
        all_in = ($urandom_range(0, 99) < 50);
        q.top    = 32'(longint'($signed(s.top)) - pick_margin(all_in));
        q.bottom = 32'(longint'($signed(s.bottom)) + pick_margin(all_in));
        q.left   = 32'(longint'($signed(s.left)) + pick_margin(all_in));
        q.right  = 32'(longint'($signed(s.right)) - pick_margin(all_in));
        return q;
    endfunction

    // random mix: stores, lookups aimed at stored boxes, and noise
    task automatic random_items(input int unsigned count);
        int unsigned k, r;
        for (k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                send_item(ACT_STORE, (r < 12) ? random_box() : noise_box(), $urandom());
            end else if (r < 85 && sb.fill > 0) begin
                send_item(ACT_LOOKUP, enclosed_query($urandom_range(0, sb.fill - 1)),
                          $urandom());
            end else begin
                send_item(ACT_LOOKUP, noise_box(), $urandom());
            end
        end
    endtask

    // directed transactions: edge cases and extremes
    task automatic directed_items();
        send_item(ACT_LOOKUP, '{32'sd950, -32'sd950, -32'sd950, 32'sd950}, 32'h0);
        // first slot and an identical second one
        send_item(ACT_STORE, '{32'sd1000, -32'sd1000, -32'sd1000, 32'sd1000}, 32'haaaa_0001);
        send_item(ACT_LOOKUP, '{32'sd950, -32'sd950, -32'sd950, 32'sd950}, 32'h0);
        send_item(ACT_LOOKUP, '{32'sd1000, -32'sd950, -32'sd950, 32'sd950}, 32'h0);
        send_item(ACT_LOOKUP, '{32'sd900, -32'sd950, -32'sd950, 32'sd950}, 32'h0);
        send_item(ACT_LOOKUP, '{32'sd901, -32'sd901, -32'sd901, 32'sd901}, 32'hffff_ffff);
        send_item(ACT_STORE, '{32'sd1000, -32'sd1000, -32'sd1000, 32'sd1000}, 32'h5555_0002);
        send_item(ACT_LOOKUP, '{32'sd950, -32'sd950, -32'sd950, 32'sd950}, 32'h0);
        // full-range box, then queries with margins of 1 and near 2^32
        send_item(ACT_STORE, '{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff},
                  32'hffff_ffff);
        send_item(ACT_LOOKUP, '{32'h7fff_fffe, 32'h8000_0001, 32'h8000_0001, 32'h7fff_fffe},
                  32'h0);
        send_item(ACT_LOOKUP, '{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000},
                  32'h0);
        // inverted box that can never enclose anything
        send_item(ACT_STORE, '{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000},
                  32'h0);
        send_item(ACT_STORE, '{32'sd50, -32'sd50, -32'sd50, 32'sd50}, 32'h0000_1234);
        send_item(ACT_LOOKUP, '{32'sd0, 32'sd0, 32'sd0, 32'sd0}, 32'h0);
        // zero sensitivity: everything misses
        set_sensitivity(31'd0);
        send_item(ACT_LOOKUP, '{32'sd950, -32'sd950, -32'sd950, 32'sd950}, 32'h0);
        send_item(ACT_LOOKUP, '{32'sd0, 32'sd0, 32'sd0, 32'sd0}, 32'h0);
        // largest sensitivity: margin just below and exactly at the limit
        set_sensitivity(31'h7fff_ffff);
        send_item(ACT_LOOKUP, '{32'sd1, -32'sd2, -32'sd2, 32'sd1000}, 32'h0);
        send_item(ACT_LOOKUP, '{32'sd0, -32'sd2, -32'sd2, 32'sd1000}, 32'h0);
        send_item(ACT_LOOKUP, '{32'sd1, -32'sd2, -32'sd2, 32'sd1}, 32'h0);
    endtask

    // main sequence
    initial begin
        logic [30:0] sens_list[8];
        int unsigned p;
        sb = new();
        sens_list = '{31'd0, 31'h7fff_ffff, 31'd1, 31'd2, 31'd100, 31'd1000,
                      31'($urandom()), 31'($urandom_range(3, 50))};
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_items();

        for (p = 0; p < 8; p++) begin
            set_sensitivity(sens_list[p]);
            idle_on = (p % 3 != 2);
            if (p == 1) begin
                // receiver holds off while the sender keeps offering
                random_items(60);
                long_hold = 400;
                random_items(PHASE_ITEMS - 60);
            end else if (p == 3) begin
                // sender pauses until every reply is back
                random_items(PHASE_ITEMS / 2);
                wait_drained();
                random_items(PHASE_ITEMS / 2);
            end else begin
                random_items(PHASE_ITEMS);
            end
        end

        wait_drained();
        $display("Run covered %0d stores, %0d dropped full-table stores, %0d hits, %0d misses",
                 sb.n_stored, sb.n_full, sb.n_hit, sb.n_miss);
        $display("over %0d sensitivity settings with random stalls on both sides",
                 n_settings);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
